// ----- rtl/erb_pkg.sv -----
// ----------------------------------------------------------------------------
// erb_pkg
// Shared types and constants of the euclidean rhythm bank.
// ----------------------------------------------------------------------------
package erb_pkg;

  localparam int ERB_CHANNELS = 5;
  localparam int REG_W        = 20;
  localparam int TRIG_W       = 5;
  localparam int APB_DW       = 32;
  localparam int APB_AW       = 4;

  localparam logic [1:0] REG_HITS_FIRST  = 2'd0;
  localparam logic [1:0] REG_LEN_FIRST   = 2'd1;
  localparam logic [1:0] REG_HITS_SECOND = 2'd2;
  localparam logic [1:0] REG_LEN_SECOND  = 2'd3;

  localparam logic [REG_W-1:0] HITS_FIRST_RST  = 20'h54332;
  localparam logic [REG_W-1:0] LEN_FIRST_RST   = 20'hB9875;
  localparam logic [REG_W-1:0] HITS_SECOND_RST = 20'h76543;
  localparam logic [REG_W-1:0] LEN_SECOND_RST  = 20'h98764;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MODS,
    ST_MUL,
    ST_MODP,
    ST_NEXT,
    ST_DONE
  } erb_state_t;

endpackage

// ----- rtl/erb_if.sv -----
// ----------------------------------------------------------------------------
// erb_if
// Valid/ready channels of the euclidean rhythm bank.
// ----------------------------------------------------------------------------
interface erb_in_if;
  logic valid;
  logic ready;
  logic rising_edge;
  logic normal_mode;

  modport source (output valid, output rising_edge, output normal_mode, input ready);
  modport sink (input valid, input rising_edge, input normal_mode, output ready);
endinterface

interface erb_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] trigger_group_a;
  logic [4:0] trigger_group_b;

  modport source (output valid, output trigger_group_a, output trigger_group_b, input ready);
  modport sink (input valid, input trigger_group_a, input trigger_group_b, output ready);
endinterface

// ----- rtl/euclidean_rhythm_bank_top.sv -----
// ----------------------------------------------------------------------------
// euclidean_rhythm_bank_top
// Two groups of euclidean rhythm channels walked through one shared
// shift-subtract remainder unit; one pair of trigger masks per item.
// ----------------------------------------------------------------------------
// item without edge: idle straight to done, result registered
// in done once the output is free; item with edge: per channel
// load, 5 remainder steps, if needed multiply, 8 remainder steps,
// advance, over 2*CHANNELS channels, then done; one item at a time
// reset: config registers to defaults, all steps zero, no clearing pass
module euclidean_rhythm_bank_top #(
  parameter int CHANNELS = erb_pkg::ERB_CHANNELS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  erb_in_if.sink                       in_ch,
  erb_out_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [erb_pkg::APB_AW-1:0]   paddr,
  input  logic [erb_pkg::APB_DW-1:0]   pwdata,
  output logic [erb_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import erb_pkg::*;

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // config registers
  logic [REG_W-1:0] hits1_r, len1_r, hits2_r, len2_r;
  logic             cfg_we;
  logic [1:0]       cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits1_r <= HITS_FIRST_RST;
      len1_r  <= LEN_FIRST_RST;
      hits2_r <= HITS_SECOND_RST;
      len2_r  <= LEN_SECOND_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_HITS_FIRST:  hits1_r <= pwdata[REG_W-1:0];
        REG_LEN_FIRST:   len1_r  <= pwdata[REG_W-1:0];
        REG_HITS_SECOND: hits2_r <= pwdata[REG_W-1:0];
        REG_LEN_SECOND:  len2_r  <= pwdata[REG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_HITS_FIRST:  prdata = APB_DW'(hits1_r);
      REG_LEN_FIRST:   prdata = APB_DW'(len1_r);
      REG_HITS_SECOND: prdata = APB_DW'(hits2_r);
      REG_LEN_SECOND:  prdata = APB_DW'(len2_r);
    endcase
  end

  // sequencer and datapath registers
  erb_state_t        state_r, state_nxt;
  logic [CW-1:0]     ch_r, ch_nxt;
  logic              grp_r, grp_nxt;
  logic              mode_r, mode_nxt;
  logic [3:0]        k_r, k_nxt;
  logic [3:0]        n_r, n_nxt;
  logic [7:0]        dvd_r, dvd_nxt;
  logic [3:0]        rem_r, rem_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic [3:0]        s_r, s_nxt;
  logic [CHANNELS-1:0] mask_a_r, mask_a_nxt;
  logic [CHANNELS-1:0] mask_b_r, mask_b_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [TRIG_W-1:0] trig_a_r, trig_a_nxt;
  logic [TRIG_W-1:0] trig_b_r, trig_b_nxt;

  logic [3:0]        steps_a_r [CHANNELS];
  logic [3:0]        steps_b_r [CHANNELS];
  logic              step_we;
  logic [3:0]        step_wd;

  logic              in_acc;
  logic              out_free;
  logic              last_ch;
  logic              use_first;
  logic [REG_W-1:0]  k_reg, n_reg;
  logic [31:0]       k_word, n_word;
  logic [4:0]        nib_pos;
  logic [3:0]        k_sel, n_sel;
  logic [3:0]        old_step;
  logic [4:0]        old_p1;
  logic              pulse_set;

  // shared remainder step
  logic [4:0]        t5;
  logic              t_ge;
  logic [3:0]        rem_step;

  assign in_ch.ready            = (state_r == ST_IDLE);
  assign in_acc                 = in_ch.valid && in_ch.ready;
  assign out_free               = !out_valid_r || out_ch.ready;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.trigger_group_a = trig_a_r;
  assign out_ch.trigger_group_b = trig_b_r;
  assign last_ch                = (ch_r == CW'(CHANNELS - 1));

  assign use_first = grp_r ? !mode_r : mode_r;
  assign k_reg     = use_first ? hits1_r : hits2_r;
  assign n_reg     = use_first ? len1_r : len2_r;
  assign k_word    = 32'(k_reg);
  assign n_word    = 32'(n_reg);
  assign nib_pos   = 5'(ch_r) << 2;
  assign k_sel     = k_word[nib_pos +: 4];
  assign n_sel     = n_word[nib_pos +: 4];
  assign old_step  = grp_r ? steps_b_r[ch_r] : steps_a_r[ch_r];
  assign old_p1    = 5'(old_step) + 5'd1;

  assign t5       = {rem_r, dvd_r[7]};
  assign t_ge     = (t5 >= {1'b0, n_r});
  assign rem_step = t_ge ? 4'(t5 - {1'b0, n_r}) : t5[3:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = in_ch.rising_edge ? ST_LOAD : ST_DONE;
      end
      ST_LOAD: begin
        state_nxt = (n_sel == 4'd0) ? ST_NEXT : ST_MODS;
      end
      ST_MODS: begin
        if (cnt_r == 3'd0) begin
          if (k_r == 4'd0 || k_r >= n_r || rem_step == 4'd0) state_nxt = ST_NEXT;
          else state_nxt = ST_MUL;
        end
      end
      ST_MUL: state_nxt = ST_MODP;
      ST_MODP: begin
        if (cnt_r == 3'd0) state_nxt = ST_NEXT;
      end
      ST_NEXT: begin
        state_nxt = (last_ch && grp_r) ? ST_DONE : ST_LOAD;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    ch_nxt        = ch_r;
    grp_nxt       = grp_r;
    mode_nxt      = mode_r;
    k_nxt         = k_r;
    n_nxt         = n_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    s_nxt         = s_r;
    mask_a_nxt    = mask_a_r;
    mask_b_nxt    = mask_b_r;
    trig_a_nxt    = trig_a_r;
    trig_b_nxt    = trig_b_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    step_we       = 1'b0;
    step_wd       = 4'd0;
    pulse_set     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          mode_nxt   = in_ch.normal_mode;
          ch_nxt     = '0;
          grp_nxt    = 1'b0;
          mask_a_nxt = '0;
          mask_b_nxt = '0;
        end
      end
      ST_LOAD: begin
        k_nxt   = k_sel;
        n_nxt   = n_sel;
        rem_nxt = 4'd0;
        cnt_nxt = 3'd4;
        dvd_nxt = {old_p1, 3'b000};
        if (n_sel == 4'd0) begin
          step_we = 1'b1;
          step_wd = 4'd0;
        end
      end
      ST_MODS: begin
        rem_nxt = rem_step;
        dvd_nxt = {dvd_r[6:0], 1'b0};
        cnt_nxt = cnt_r - 3'd1;
        if (cnt_r == 3'd0) begin
          s_nxt   = rem_step;
          step_we = 1'b1;
          step_wd = rem_step;
          if (k_r == 4'd0) pulse_set = 1'b0;
          else if (k_r >= n_r) pulse_set = 1'b1;
          else if (rem_step == 4'd0) pulse_set = (k_r >= 4'd2);
        end
      end
      ST_MUL: begin
        dvd_nxt = {4'd0, s_r} * {4'd0, k_r};
        rem_nxt = 4'd0;
        cnt_nxt = 3'd7;
      end
      ST_MODP: begin
        rem_nxt = rem_step;
        dvd_nxt = {dvd_r[6:0], 1'b0};
        cnt_nxt = cnt_r - 3'd1;
        if (cnt_r == 3'd0) pulse_set = (rem_step < k_r);
      end
      ST_NEXT: begin
        if (last_ch) begin
          ch_nxt  = '0;
          grp_nxt = 1'b1;
        end else begin
          ch_nxt = ch_r + CW'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          trig_a_nxt    = TRIG_W'(mask_a_r);
          trig_b_nxt    = TRIG_W'(mask_b_r);
        end
      end
      default: ;
    endcase
    if (pulse_set) begin
      if (grp_r) mask_b_nxt[ch_r] = 1'b1;
      else mask_a_nxt[ch_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        steps_a_r[i] <= 4'd0;
        steps_b_r[i] <= 4'd0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (step_we) begin
        if (grp_r) steps_b_r[ch_r] <= step_wd;
        else steps_a_r[ch_r] <= step_wd;
      end
    end
  end

  always_ff @(posedge clk) begin
    ch_r     <= ch_nxt;
    grp_r    <= grp_nxt;
    mode_r   <= mode_nxt;
    k_r      <= k_nxt;
    n_r      <= n_nxt;
    dvd_r    <= dvd_nxt;
    rem_r    <= rem_nxt;
    cnt_r    <= cnt_nxt;
    s_r      <= s_nxt;
    mask_a_r <= mask_a_nxt;
    mask_b_r <= mask_b_nxt;
    trig_a_r <= trig_a_nxt;
    trig_b_r <= trig_b_nxt;
  end

  // assertions
  a_no_edge_done: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_ch.rising_edge) |=> (state_r == ST_DONE))
    else $error("item without edge did not go straight to done");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MODS || state_r == ST_MODP) |-> (rem_r < n_r))
    else $error("partial remainder not below length");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> (s_r < n_r && s_r != 4'd0 && k_r < n_r))
    else $error("bad step or hits at multiply");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside done");

endmodule
